### rtl/markov_transition_sampler_macros.svh
// Assertion macros shared by the markov transition sampler RTL.
`ifndef MARKOV_TRANSITION_SAMPLER_MACROS_SVH
`define MARKOV_TRANSITION_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mts_pkg.sv
// Types and constants of the markov transition sampler.
`default_nettype none
package mts_pkg;

    // Fixed field widths of the stream payloads
    localparam int SYM_W        = 4;
    localparam int RND_W        = 32;
    localparam int IN_TDATA_W   = 2 * SYM_W + RND_W;
    localparam int OUT_TDATA_W  = 8;
    localparam int SYM_CMP_W    = 9;
    localparam int ADDR_CALC_W  = 17;

    // Divider step counter
    localparam int BIT_W = $clog2(RND_W);
    localparam logic [BIT_W-1:0] DIV_LAST = BIT_W'(RND_W - 1);

    typedef enum logic {
        CMD_RECORD = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REC_RD,
        ST_REC_WR,
        ST_SUM,
        ST_DIV,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

### rtl/mts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mts_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/mts_alu.sv
// Shared add/subtract unit used for increment, row sum, divide and row walk.
`default_nettype none
module mts_alu #(
    parameter int W = 21
) (
    input  mts_pkg::t_alu_op i_op,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [W-1:0]     o_res,
    output logic             o_carry
);
    import mts_pkg::*;

    logic [W-1:0] w_b;
    logic         w_cin;
    logic [W:0]   w_sum;

    // Invert the second operand for subtract; carry out means a >= b
    always_comb begin
        unique case (i_op)
            ALU_ADD: begin
                w_b   = i_b;
                w_cin = 1'b0;
            end
            ALU_SUB: begin
                w_b   = ~i_b;
                w_cin = 1'b1;
            end
        endcase
    end

    assign w_sum   = {1'b0, i_a} + {1'b0, w_b} + (W + 1)'(w_cin);
    assign o_res   = w_sum[W-1:0];
    assign o_carry = w_sum[W];

endmodule
`default_nettype wire

### rtl/markov_transition_sampler.sv
// Markov transition sampler: count table, sequencer and result register.
//
// Keeps a NUM_SYMBOLS x NUM_SYMBOLS table of saturating transition counts in
// a RAM. A record request (tuser 0) adds one to the (from, to) count and gives
// no result; its steps are accept, read and write back. A sample request
// (tuser 1) sums the from row, reduces the random word modulo that sum with a
// restoring divider one bit per cycle, and walks the row again to pick the
// next symbol; the sum, the divide and the walk all share the one
// adder/subtractor and the single RAM read port. An empty or out-of-range row
// returns symbol 0 with status 1 in tuser. After reset the block clears the
// table one entry per cycle and accepts no request until that pass ends. One
// request is worked at a time; a new one is accepted while a finished result
// still waits on the master side.
`default_nettype none
module markov_transition_sampler #(
    parameter int NUM_SYMBOLS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // from_symbol [3:0], to_symbol [7:4], random_value [39:8]
    input  logic [mts_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // command [0]
    input  logic [0:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // next_symbol [3:0], zero fill [7:4]
    output logic [mts_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // status [0]
    output logic [0:0]                         o_m_axis_tuser
);
    import mts_pkg::*;

`include "markov_transition_sampler_macros.svh"

    localparam int DEPTH = NUM_SYMBOLS * NUM_SYMBOLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(NUM_SYMBOLS);
    localparam int SW    = COUNT_WIDTH + CW;
    localparam int ALU_W = SW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(NUM_SYMBOLS - 1);

    // Request fields
    logic [SYM_W-1:0]       s_from;
    logic [SYM_W-1:0]       s_to;
    logic [RND_W-1:0]       s_rnd;
    t_cmd                   s_cmd;
    logic                   s_acc;
    logic                   w_from_ok;
    logic                   w_to_ok;
    logic [ADDR_CALC_W-1:0] w_row_base;
    logic [ADDR_CALC_W-1:0] w_rec_addr;

    // State
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_base, n_base;
    logic [RND_W-1:0]  r_rnd, n_rnd;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [SW-1:0]     r_sum, n_sum;
    logic [SW-1:0]     r_rem, n_rem;
    logic [CW-1:0]     r_col, n_col;
    logic              r_issue, n_issue;
    logic              r_dv, n_dv;
    logic [CW-1:0]     r_dcol, n_dcol;
    logic [CW-1:0]     r_pick, n_pick;
    logic              r_status, n_status;
    logic              r_m_tvalid, n_m_tvalid;
    logic [SYM_W-1:0]  r_m_sym, n_m_sym;
    logic              r_m_status, n_m_status;

    // RAM and ALU hookup
    logic                   w_ram_we;
    logic [AW-1:0]          w_ram_waddr;
    logic [COUNT_WIDTH-1:0] w_ram_wdata;
    logic [AW-1:0]          w_ram_raddr;
    logic [COUNT_WIDTH-1:0] w_ram_q;
    t_alu_op                w_alu_op;
    logic [ALU_W-1:0]       w_alu_a;
    logic [ALU_W-1:0]       w_alu_b;
    logic [ALU_W-1:0]       w_alu_res;
    logic                   w_alu_carry;
    logic                   w_out_free;
    logic                   w_sum_last;

    // Unpack the request
    assign s_from = i_s_axis_tdata[SYM_W-1:0];
    assign s_to   = i_s_axis_tdata[2*SYM_W-1:SYM_W];
    assign s_rnd  = i_s_axis_tdata[2*SYM_W+RND_W-1:2*SYM_W];
    assign s_cmd  = t_cmd'(i_s_axis_tuser[0]);
    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;

    assign w_from_ok  = SYM_CMP_W'(s_from) < SYM_CMP_W'(NUM_SYMBOLS);
    assign w_to_ok    = SYM_CMP_W'(s_to) < SYM_CMP_W'(NUM_SYMBOLS);
    assign w_row_base = ADDR_CALC_W'(s_from) * ADDR_CALC_W'(NUM_SYMBOLS);
    assign w_rec_addr = w_row_base + ADDR_CALC_W'(s_to);

    assign w_out_free = !r_m_tvalid || i_m_axis_tready;
    assign w_sum_last = r_dv && (r_dcol == LAST_COL);

    mts_ram #(
        .W     (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_q)
    );

    mts_alu #(
        .W (ALU_W)
    ) u_alu (
        .i_op    (w_alu_op),
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .o_res   (w_alu_res),
        .o_carry (w_alu_carry)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_cmd == CMD_RECORD) begin
                        n_state = (w_from_ok && w_to_ok) ? ST_REC_RD : ST_IDLE;
                    end else begin
                        n_state = w_from_ok ? ST_SUM : ST_DONE;
                    end
                end
            end
            ST_REC_RD: n_state = ST_REC_WR;
            ST_REC_WR: n_state = ST_IDLE;
            ST_SUM: begin
                if (w_sum_last) n_state = (n_sum == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (r_bit == DIV_LAST) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (r_dv && !w_alu_carry) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath controls and next register values
    always_comb begin
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_base      = r_base;
        n_rnd       = r_rnd;
        n_bit       = r_bit;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_col       = r_col;
        n_issue     = r_issue;
        n_dv        = r_dv;
        n_dcol      = r_dcol;
        n_pick      = r_pick;
        n_status    = r_status;
        n_m_tvalid  = r_m_tvalid;
        n_m_sym     = r_m_sym;
        n_m_status  = r_m_status;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_addr;
        w_ram_wdata = '0;
        w_ram_raddr = r_addr;
        w_alu_op    = ALU_ADD;
        w_alu_a     = '0;
        w_alu_b     = '0;

        // Drop the result once the master side takes it
        if (r_m_tvalid && i_m_axis_tready) n_m_tvalid = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                n_clr       = r_clr + AW'(1);
            end
            ST_IDLE: begin
                if (s_acc) begin
                    n_addr   = AW'(w_rec_addr);
                    n_base   = AW'(w_row_base);
                    n_rnd    = s_rnd;
                    n_bit    = '0;
                    n_sum    = '0;
                    n_rem    = '0;
                    n_col    = '0;
                    n_issue  = 1'b1;
                    n_dv     = 1'b0;
                    n_pick   = '0;
                    n_status = STATUS_EMPTY;
                end
            end
            ST_REC_RD: begin
                w_ram_raddr = r_addr;
            end
            ST_REC_WR: begin
                // Increment and write back unless already saturated
                w_alu_op    = ALU_ADD;
                w_alu_a     = ALU_W'(w_ram_q);
                w_alu_b     = ALU_W'(1);
                w_ram_we    = !w_alu_res[COUNT_WIDTH];
                w_ram_wdata = w_alu_res[COUNT_WIDTH-1:0];
            end
            ST_SUM: begin
                w_ram_raddr = r_base + AW'(r_col);
                n_col       = r_col + CW'(1);
                n_issue     = r_issue && (r_col != LAST_COL);
                n_dv        = r_issue;
                n_dcol      = r_col;
                w_alu_op    = ALU_ADD;
                w_alu_a     = {1'b0, r_sum};
                w_alu_b     = ALU_W'(w_ram_q);
                if (r_dv) n_sum = w_alu_res[SW-1:0];
            end
            ST_DIV: begin
                // One restoring divide step per cycle, random word MSB first
                w_alu_op = ALU_SUB;
                w_alu_a  = {r_rem, r_rnd[RND_W-1]};
                w_alu_b  = {1'b0, r_sum};
                n_rem    = w_alu_carry ? w_alu_res[SW-1:0] : w_alu_a[SW-1:0];
                n_rnd    = {r_rnd[RND_W-2:0], 1'b0};
                n_bit    = r_bit + BIT_W'(1);
                n_col    = '0;
                n_issue  = 1'b1;
                n_dv     = 1'b0;
            end
            ST_WALK: begin
                // Take counts off the remainder until one exceeds it
                w_ram_raddr = r_base + AW'(r_col);
                n_col       = r_col + CW'(1);
                n_issue     = r_issue && (r_col != LAST_COL);
                n_dv        = r_issue;
                n_dcol      = r_col;
                w_alu_op    = ALU_SUB;
                w_alu_a     = {1'b0, r_rem};
                w_alu_b     = ALU_W'(w_ram_q);
                if (r_dv) begin
                    if (w_alu_carry) begin
                        n_rem = w_alu_res[SW-1:0];
                    end else begin
                        n_pick   = r_dcol;
                        n_status = STATUS_OK;
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_sym    = SYM_W'(r_pick);
                    n_m_status = r_status;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_issue    <= 1'b0;
            r_dv       <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_issue    <= n_issue;
            r_dv       <= n_dv;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_base     <= n_base;
        r_rnd      <= n_rnd;
        r_bit      <= n_bit;
        r_sum      <= n_sum;
        r_rem      <= n_rem;
        r_col      <= n_col;
        r_dcol     <= n_dcol;
        r_pick     <= n_pick;
        r_status   <= n_status;
        r_m_sym    <= n_m_sym;
        r_m_status <= n_m_status;
    end

    // Drive the ports
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_m_sym);
    assign o_m_axis_tuser  = r_m_status;

    // Checks
    `MTS_ASSERT_IMP(a_rem_below_sum, i_clk, i_rst_n, (r_state == ST_DIV || r_state == ST_WALK), (r_rem < r_sum), "remainder not below row sum")
    `MTS_ASSERT_IMP(a_valid_from_done, i_clk, i_rst_n, $rose(r_m_tvalid), ($past(r_state) == ST_DONE), "result raised outside done state")
    `MTS_ASSERT_IMP(a_empty_zero_sym, i_clk, i_rst_n, (r_m_tvalid && r_m_status == STATUS_EMPTY), (r_m_sym == '0), "empty row result carries a symbol")
    `MTS_ASSERT_NXT(a_rec_back_idle, i_clk, i_rst_n, (r_state == ST_REC_WR), o_s_axis_tready, "record did not return to idle")

endmodule
`default_nettype wire
